// ===== rtl/core/bqlpf_pkg.sv =====
package bqlpf_pkg;

  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int COEF_FRAC_BITS_DEF = 16;
  localparam int STATE_WIDTH_DEF    = 48;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FILTER_ENABLE,
    REG_COEF_B0,
    REG_COEF_B1,
    REG_COEF_B2,
    REG_COEF_A1,
    REG_COEF_A2
  } reg_idx_t;

  // Datapath controls carried by one microcode word.
  typedef enum logic [1:0] {
    SRC_D1,
    SRC_D2,
    SRC_W0
  } src_t;

  typedef enum logic [2:0] {
    CSEL_A1,
    CSEL_A2,
    CSEL_B0,
    CSEL_B1,
    CSEL_B2
  } csel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ROUND_FB,
    OP_MAKE_W0,
    OP_ROUND_OUT,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_IF_DISABLED,
    JMP_WAIT_OUT
  } jmp_t;

  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE      = 5'd0;
  localparam step_t STEP_FIRST_MUL = 5'd1;
  localparam step_t STEP_EMIT      = 5'd16;

  typedef struct packed {
    src_t    src;
    csel_t   csel;
    logic    hi;
    acc_op_t acc_op;
    op_t     op;
    jmp_t    jmp;
    step_t   target;
  } ctrl_word_t;

  function automatic ctrl_word_t uw(input src_t src, input csel_t csel, input logic hi,
                                    input acc_op_t acc_op, input op_t op, input jmp_t jmp,
                                    input step_t target);
    ctrl_word_t w;
    w.src    = src;
    w.csel   = csel;
    w.hi     = hi;
    w.acc_op = acc_op;
    w.op     = op;
    w.jmp    = jmp;
    w.target = target;
    return w;
  endfunction

  // Each multiply step issues one partial product; the accumulate field of the
  // following step adds that registered product.
  function automatic ctrl_word_t ucode_rom(input step_t step);
    ctrl_word_t w;
    case (step)
      5'd0:  w = uw(SRC_D1, CSEL_A1, 1'b0, ACC_HOLD, OP_NONE, JMP_WAIT_IN, STEP_IDLE);
      5'd1:  w = uw(SRC_D1, CSEL_A1, 1'b0, ACC_HOLD, OP_NONE, JMP_IF_DISABLED, STEP_EMIT);
      5'd2:  w = uw(SRC_D1, CSEL_A1, 1'b1, ACC_LOAD, OP_NONE, JMP_NEXT, STEP_IDLE);
      5'd3:  w = uw(SRC_D2, CSEL_A2, 1'b0, ACC_ADD,  OP_NONE, JMP_NEXT, STEP_IDLE);
      5'd4:  w = uw(SRC_D2, CSEL_A2, 1'b1, ACC_ADD,  OP_NONE, JMP_NEXT, STEP_IDLE);
      5'd5:  w = uw(SRC_D1, CSEL_A1, 1'b0, ACC_ADD,  OP_NONE, JMP_NEXT, STEP_IDLE);
      5'd6:  w = uw(SRC_D1, CSEL_A1, 1'b0, ACC_HOLD, OP_ROUND_FB, JMP_NEXT, STEP_IDLE);
      5'd7:  w = uw(SRC_D1, CSEL_A1, 1'b0, ACC_HOLD, OP_MAKE_W0, JMP_NEXT, STEP_IDLE);
      5'd8:  w = uw(SRC_W0, CSEL_B0, 1'b0, ACC_HOLD, OP_NONE, JMP_NEXT, STEP_IDLE);
      5'd9:  w = uw(SRC_W0, CSEL_B0, 1'b1, ACC_LOAD, OP_NONE, JMP_NEXT, STEP_IDLE);
      5'd10: w = uw(SRC_D1, CSEL_B1, 1'b0, ACC_ADD,  OP_NONE, JMP_NEXT, STEP_IDLE);
      5'd11: w = uw(SRC_D1, CSEL_B1, 1'b1, ACC_ADD,  OP_NONE, JMP_NEXT, STEP_IDLE);
      5'd12: w = uw(SRC_D2, CSEL_B2, 1'b0, ACC_ADD,  OP_NONE, JMP_NEXT, STEP_IDLE);
      5'd13: w = uw(SRC_D2, CSEL_B2, 1'b1, ACC_ADD,  OP_NONE, JMP_NEXT, STEP_IDLE);
      5'd14: w = uw(SRC_D1, CSEL_B0, 1'b0, ACC_ADD,  OP_NONE, JMP_NEXT, STEP_IDLE);
      5'd15: w = uw(SRC_D1, CSEL_B0, 1'b0, ACC_HOLD, OP_ROUND_OUT, JMP_NEXT, STEP_IDLE);
      5'd16: w = uw(SRC_D1, CSEL_B0, 1'b0, ACC_HOLD, OP_EMIT, JMP_WAIT_OUT, STEP_IDLE);
      default: w = uw(SRC_D1, CSEL_A1, 1'b0, ACC_HOLD, OP_NONE, JMP_NEXT, STEP_IDLE);
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/bqlpf_in_if.sv =====
interface bqlpf_in_if import bqlpf_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

// ===== rtl/core/bqlpf_out_if.sv =====
interface bqlpf_out_if import bqlpf_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           guard_taken;

  modport source (output valid, output sample_out, output guard_taken, input ready);
  modport sink (input valid, input sample_out, input guard_taken, output ready);
endinterface

// ===== rtl/core/biquad_lowpass_filter.sv =====
// Each accepted input beat runs the microcode program up to the emit step; when disabled the
// program skips to the emit step (sample passes through). A new input beat is taken only in
// the idle step, so one sample is in flight at a time; the program drives a single split
// multiplier (ten partial products per sample). Reset (synchronous, active low) clears the
// delays, configuration registers, step counter and output valid flag.
module biquad_lowpass_filter import bqlpf_pkg::*; #(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  parameter int STATE_WIDTH    = STATE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bqlpf_in_if.sink              in_chan,
  bqlpf_out_if.source           out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int COEF_W = COEF_FRAC_BITS + 4;
  localparam int LO_W   = (STATE_WIDTH + 1) / 2;
  localparam int HI_W   = STATE_WIDTH - LO_W;
  localparam int PROD_W = LO_W + 1 + COEF_W;
  localparam int ACC_W  = STATE_WIDTH + COEF_W + 2;

  localparam logic signed [ACC_W-1:0] RND_FB  = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] RND_OUT = ACC_W'(1) << (2 * COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] STATE_MAX =
    (ACC_W'(1) << (STATE_WIDTH - 1)) - ACC_W'(1);
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // Configuration registers.
  logic                     enable_r;
  logic signed [COEF_W-1:0] coef_b0_r, coef_b1_r, coef_b2_r, coef_a1_r, coef_a2_r;

  // Sequencer and datapath registers.
  step_t                         step_r, step_nxt;
  ctrl_word_t                    cw;
  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic signed [STATE_WIDTH-1:0] delay1_r, delay2_r, w0_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic                          prod_hi_r;
  logic signed [ACC_W-1:0]       acc_r, rnd_r;
  logic                          guard_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r;
  logic                          out_guard_r;

  // Combinational datapath.
  logic                          cfg_wr;
  reg_idx_t                      cfg_idx;
  logic                          in_fire, out_free, emit_fire;
  logic signed [STATE_WIDTH-1:0] mul_src;
  logic signed [LO_W:0]          mul_a;
  logic signed [COEF_W-1:0]      mul_c;
  logic signed [ACC_W-1:0]       addend, xs_w, diff_w, w0_sat;
  logic [ACC_W-STATE_WIDTH:0]    diff_top;
  logic [ACC_W-SAMPLE_WIDTH:0]   rnd_top;
  logic                          diff_fits, rnd_fits;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      coef_b0_r <= '0;
      coef_b1_r <= '0;
      coef_b2_r <= '0;
      coef_a1_r <= '0;
      coef_a2_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FILTER_ENABLE: enable_r  <= pwdata[0];
        REG_COEF_B0:       coef_b0_r <= pwdata[COEF_W-1:0];
        REG_COEF_B1:       coef_b1_r <= pwdata[COEF_W-1:0];
        REG_COEF_B2:       coef_b2_r <= pwdata[COEF_W-1:0];
        REG_COEF_A1:       coef_a1_r <= pwdata[COEF_W-1:0];
        REG_COEF_A2:       coef_a2_r <= pwdata[COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FILTER_ENABLE: prdata = {{(APB_DATA_W-1){1'b0}}, enable_r};
      REG_COEF_B0:       prdata = {{(APB_DATA_W-COEF_W){1'b0}}, coef_b0_r};
      REG_COEF_B1:       prdata = {{(APB_DATA_W-COEF_W){1'b0}}, coef_b1_r};
      REG_COEF_B2:       prdata = {{(APB_DATA_W-COEF_W){1'b0}}, coef_b2_r};
      REG_COEF_A1:       prdata = {{(APB_DATA_W-COEF_W){1'b0}}, coef_a1_r};
      REG_COEF_A2:       prdata = {{(APB_DATA_W-COEF_W){1'b0}}, coef_a2_r};
      default:           prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  assign cw        = ucode_rom(step_r);
  assign in_fire   = in_chan.valid & in_chan.ready;
  assign out_free  = ~out_valid_r | out_chan.ready;
  assign emit_fire = (cw.op == OP_EMIT) & out_free;

  always_comb begin
    case (cw.jmp)
      JMP_NEXT:        step_nxt = step_t'(step_r + 1'b1);
      JMP_WAIT_IN:     step_nxt = in_fire ? step_t'(step_r + 1'b1) : step_r;
      JMP_IF_DISABLED: step_nxt = enable_r ? step_t'(step_r + 1'b1) : cw.target;
      JMP_WAIT_OUT:    step_nxt = out_free ? cw.target : step_r;
      default:         step_nxt = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign in_chan.ready = (cw.jmp == JMP_WAIT_IN);

  // ---------------- datapath controls ----------------
  always_comb begin
    case (cw.src)
      SRC_D1:  mul_src = delay1_r;
      SRC_D2:  mul_src = delay2_r;
      SRC_W0:  mul_src = w0_r;
      default: mul_src = delay1_r;
    endcase
    case (cw.csel)
      CSEL_A1: mul_c = coef_a1_r;
      CSEL_A2: mul_c = coef_a2_r;
      CSEL_B0: mul_c = coef_b0_r;
      CSEL_B1: mul_c = coef_b1_r;
      CSEL_B2: mul_c = coef_b2_r;
      default: mul_c = coef_a1_r;
    endcase
    // The state word is split into an unsigned low half and a signed high half.
    if (cw.hi) begin
      mul_a = {{(LO_W+1-HI_W){mul_src[STATE_WIDTH-1]}}, mul_src[STATE_WIDTH-1:LO_W]};
    end else begin
      mul_a = {1'b0, mul_src[LO_W-1:0]};
    end
  end

  always_comb begin
    addend = ACC_W'(prod_r);
    if (prod_hi_r) begin
      addend = addend <<< LO_W;
    end
  end

  assign xs_w      = ACC_W'(x_r) <<< COEF_FRAC_BITS;
  assign diff_w    = xs_w - rnd_r;
  assign diff_top  = diff_w[ACC_W-1:STATE_WIDTH-1];
  assign diff_fits = (&diff_top) | ~(|diff_top);

  // An overflowing delay value is replaced by the scaled sample, clamped to the state range.
  always_comb begin
    if ((&xs_w[ACC_W-1:STATE_WIDTH-1]) | ~(|xs_w[ACC_W-1:STATE_WIDTH-1])) begin
      w0_sat = xs_w;
    end else if (xs_w[ACC_W-1]) begin
      w0_sat = ~STATE_MAX;
    end else begin
      w0_sat = STATE_MAX;
    end
  end

  assign rnd_top  = rnd_r[ACC_W-1:SAMPLE_WIDTH-1];
  assign rnd_fits = (&rnd_top) | ~(|rnd_top);

  always_comb begin
    if (rnd_fits) begin
      y_sat = rnd_r[SAMPLE_WIDTH-1:0];
    end else if (rnd_r[ACC_W-1]) begin
      y_sat = SAMPLE_MIN;
    end else begin
      y_sat = SAMPLE_MAX;
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    prod_r    <= mul_a * mul_c;
    prod_hi_r <= cw.hi;
    if (in_fire) begin
      x_r <= in_chan.sample_in;
    end
    case (cw.acc_op)
      ACC_LOAD: acc_r <= addend;
      ACC_ADD:  acc_r <= acc_r + addend;
      default: begin
      end
    endcase
    case (cw.op)
      OP_ROUND_FB:  rnd_r <= (acc_r + RND_FB) >>> COEF_FRAC_BITS;
      OP_ROUND_OUT: rnd_r <= (acc_r + RND_OUT) >>> (2 * COEF_FRAC_BITS);
      OP_MAKE_W0: begin
        w0_r    <= diff_fits ? diff_w[STATE_WIDTH-1:0] : w0_sat[STATE_WIDTH-1:0];
        guard_r <= ~diff_fits;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay1_r <= '0;
      delay2_r <= '0;
    end else if (emit_fire && enable_r) begin
      delay2_r <= delay1_r;
      delay1_r <= w0_r;
    end
  end

  // Output register: the next sample is taken while this beat waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_sample_r <= enable_r ? y_sat : x_r;
      out_guard_r  <= enable_r & guard_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.sample_out  = out_sample_r;
  assign out_chan.guard_taken = out_guard_r;

  // ---------------- assertions ----------------
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(step_r) == STEP_EMIT)
    else $error("output beat raised outside the emit step");

  a_accept_starts_program: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> step_r == STEP_FIRST_MUL)
    else $error("accepted sample did not start the program");

  a_no_guard_when_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire && !enable_r |=> out_valid_r && !out_guard_r)
    else $error("guard flag raised on a pass-through beat");

  a_step_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_EMIT)
    else $error("step counter left the program");

endmodule
